// ===== hw/rtl/bwpm_pkg.sv =====
// Shared types and constants for the binary window pattern marker.
package bwpm_pkg;

  // Configuration port geometry and register indexes.
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAP_WIDTH = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PATTERN   = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [4:0] MAP_WIDTH_RST = 5'd10;
  localparam logic [3:0] PATTERN_RST   = 4'd0;

  // Narrowest row the block works with.
  localparam int MIN_COLS = 2;

  // Cell value written over a matched window.
  localparam logic [1:0] CELL_MARK = 2'd2;

  // Kind of row sweep the datapath runs.
  typedef enum logic [1:0] {
    SW_ROW,        // emit the upper row if there is one, copy lower row into upper row
    SW_MAP_UPPER,  // emit the upper row at map end
    SW_MAP_LOWER   // emit the partial lower row at map end
  } sweep_mode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        take;
    logic        window;
    logic        flush;
    logic        sweep_go;
    sweep_mode_t mode;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic row_end;
    logic map_end;
    logic have_upper;
    logic sweep_busy;
  } dp_sts_t;

endpackage

// ===== hw/rtl/bwpm_ctrl.sv =====
// Controller state machine that sequences window checks and row sweeps.
module bwpm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bwpm_pkg::dp_sts_t sts,
  output bwpm_pkg::dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WIN,
    ST_FLUSH,
    ST_UPPER,
    ST_LOWER
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // Command decode and next state.
  always_comb begin
    cmd          = '0;
    cmd.mode     = bwpm_pkg::SW_ROW;
    state_nxt    = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_WIN;
        end
      end
      ST_WIN: begin
        cmd.window = 1'b1;
        if (sts.map_end || sts.row_end) begin
          state_nxt = ST_FLUSH;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        cmd.flush    = 1'b1;
        cmd.sweep_go = 1'b1;
        if (!sts.map_end) begin
          cmd.mode  = bwpm_pkg::SW_ROW;
          state_nxt = ST_UPPER;
        end else if (sts.have_upper) begin
          cmd.mode  = bwpm_pkg::SW_MAP_UPPER;
          state_nxt = ST_UPPER;
        end else begin
          cmd.mode  = bwpm_pkg::SW_MAP_LOWER;
          state_nxt = ST_LOWER;
        end
      end
      ST_UPPER: begin
        if (!sts.sweep_busy) begin
          if (sts.map_end) begin
            cmd.sweep_go = 1'b1;
            cmd.mode     = bwpm_pkg::SW_MAP_LOWER;
            state_nxt    = ST_LOWER;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_LOWER: begin
        if (!sts.sweep_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/bwpm_datapath.sv =====
// Datapath with row memories, window compare, row sweep and output register.
module bwpm_datapath #(
  parameter int MAX_COLS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bwpm_pkg::dp_cmd_t                   cmd,
  output bwpm_pkg::dp_sts_t                   sts,
  input  logic                                in_cell_bit,
  input  logic                                in_map_end,
  input  logic                                cfg_we,
  input  logic [bwpm_pkg::CFG_ADDR_W-1:0]     cfg_index,
  input  logic [bwpm_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_cell_value,
  output logic                                out_row_last,
  output logic                                out_run_last,
  output logic                                out_any_found
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int WW = $clog2(MAX_COLS + 1);

  // Configuration registers.
  logic [4:0] map_width_r;
  logic [3:0] pattern_r;

  // Map state.
  logic [CW-1:0] col_r;
  logic          have_upper_r;
  logic          found_r;
  logic [WW-1:0] hwm_r;
  logic          bit_r;
  logic          map_end_r;
  logic [1:0]    hu_r;
  logic [1:0]    hl_r;

  // Row memories and their registered read data.
  logic [1:0]    upper_mem [MAX_COLS];
  logic [1:0]    lower_mem [MAX_COLS];
  logic [1:0]    rd_u_r;
  logic [1:0]    rd_l_r;

  // Sweep state.
  logic                  sw_act_r;
  bwpm_pkg::sweep_mode_t sw_mode_r;
  logic [WW-1:0]         sw_j_r;
  logic [WW-1:0]         sw_len_r;
  logic [WW-1:0]         sw_emit_r;
  logic                  pv_r;
  logic [CW-1:0]         pidx_r;

  // Output register.
  logic       out_valid_r;
  logic [1:0] out_value_r;
  logic       out_row_last_r;
  logic       out_run_last_r;
  logic       out_any_found_r;

  logic [WW-1:0] eff_w;
  logic [WW-1:0] col_inc;
  logic          row_end;
  logic          match;
  logic          emit_this;
  logic          last_emit;
  logic          sw_adv;
  logic          sw_more;
  logic          sw_rd;
  logic          sw_copy;
  logic          sw_end;
  logic          out_load;
  logic [1:0]    emit_value;
  logic          up_we;
  logic          lo_we;
  logic [CW-1:0] up_wa;
  logic [CW-1:0] lo_wa;
  logic [1:0]    up_wd;
  logic [1:0]    lo_wd;
  logic          rd_en;
  logic [CW-1:0] rd_a;

  // Row width clamped to the supported range.
  always_comb begin
    if (map_width_r < 5'(bwpm_pkg::MIN_COLS)) begin
      eff_w = WW'(bwpm_pkg::MIN_COLS);
    end else if (map_width_r > 5'(MAX_COLS)) begin
      eff_w = WW'(MAX_COLS);
    end else begin
      eff_w = WW'(map_width_r);
    end
  end

  assign col_inc = WW'(col_r) + WW'(1);
  assign row_end = (col_inc >= eff_w);

  // The window's left column sits in hu_r/hl_r, its right column in rd_u_r and bit_r.
  assign match = have_upper_r && (col_r != '0) &&
                 (hu_r == {1'b0, pattern_r[0]}) &&
                 (rd_u_r == {1'b0, pattern_r[1]}) &&
                 (hl_r == {1'b0, pattern_r[2]}) &&
                 (bit_r == pattern_r[3]);

  // Sweep pipeline: one memory read stage, then the output register.
  assign emit_this = pv_r && (WW'(pidx_r) < sw_emit_r);
  assign last_emit = ((WW'(pidx_r) + WW'(1)) == sw_emit_r);
  assign sw_adv    = sw_act_r && (!emit_this || !out_valid_r || out_ready);
  assign sw_more   = (sw_j_r < sw_len_r);
  assign sw_rd     = sw_adv && sw_more;
  assign sw_copy   = sw_adv && pv_r && (sw_mode_r == bwpm_pkg::SW_ROW);
  assign sw_end    = sw_adv && !sw_more;
  assign out_load  = sw_adv && emit_this;

  always_comb begin
    case (sw_mode_r)
      bwpm_pkg::SW_MAP_LOWER: emit_value = rd_l_r;
      default:                emit_value = rd_u_r;
    endcase
  end

  // Memory port selection: window write-back, row-end or map-end flush, or sweep copy.
  always_comb begin
    up_we = 1'b0;
    lo_we = 1'b0;
    up_wa = col_r;
    lo_wa = col_r;
    up_wd = hu_r;
    lo_wd = hl_r;
    if (cmd.window && (col_r != '0)) begin
      up_we = 1'b1;
      lo_we = 1'b1;
      up_wa = col_r - CW'(1);
      lo_wa = col_r - CW'(1);
      up_wd = match ? bwpm_pkg::CELL_MARK : hu_r;
      lo_wd = match ? bwpm_pkg::CELL_MARK : hl_r;
    end
    if (cmd.flush) begin
      up_we = 1'b1;
      lo_we = 1'b1;
    end
    if (sw_copy) begin
      up_we = 1'b1;
      up_wa = pidx_r;
      up_wd = rd_l_r;
    end
  end

  assign rd_en = cmd.take || sw_rd;
  assign rd_a  = cmd.take ? col_r : sw_j_r[CW-1:0];

  // Row memories.
  always_ff @(posedge clk) begin
    if (up_we) begin
      upper_mem[up_wa] <= up_wd;
    end
    if (lo_we) begin
      lower_mem[lo_wa] <= lo_wd;
    end
    if (rd_en) begin
      rd_u_r <= upper_mem[rd_a];
      rd_l_r <= lower_mem[rd_a];
    end
  end

  // Payload registers for the item and the held column.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      bit_r     <= in_cell_bit;
      map_end_r <= in_map_end;
    end
    if (cmd.window) begin
      hu_r <= match ? bwpm_pkg::CELL_MARK : rd_u_r;
      hl_r <= match ? bwpm_pkg::CELL_MARK : {1'b0, bit_r};
    end
  end

  // Configuration and map control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= bwpm_pkg::MAP_WIDTH_RST;
      pattern_r    <= bwpm_pkg::PATTERN_RST;
      col_r        <= '0;
      have_upper_r <= 1'b0;
      found_r      <= 1'b0;
      hwm_r        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bwpm_pkg::CFG_MAP_WIDTH: map_width_r <= cfg_data[4:0];
          bwpm_pkg::CFG_PATTERN:   pattern_r   <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (cmd.window) begin
        if (match) begin
          found_r <= 1'b1;
        end
        if (col_inc > hwm_r) begin
          hwm_r <= col_inc;
        end
        if (!row_end && !map_end_r) begin
          col_r <= col_r + CW'(1);
        end
      end
      if (sw_end) begin
        case (sw_mode_r)
          bwpm_pkg::SW_ROW: begin
            col_r        <= '0;
            have_upper_r <= 1'b1;
          end
          bwpm_pkg::SW_MAP_LOWER: begin
            col_r        <= '0;
            have_upper_r <= 1'b0;
            found_r      <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // Sweep control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_act_r <= 1'b0;
      pv_r     <= 1'b0;
    end else begin
      if (cmd.sweep_go) begin
        sw_act_r <= 1'b1;
        pv_r     <= 1'b0;
      end else if (sw_adv) begin
        pv_r <= sw_more;
        if (!sw_more) begin
          sw_act_r <= 1'b0;
        end
      end
    end
  end

  // Sweep payload: mode, bounds and read index.
  always_ff @(posedge clk) begin
    if (cmd.sweep_go) begin
      sw_mode_r <= cmd.mode;
      sw_j_r    <= '0;
      case (cmd.mode)
        bwpm_pkg::SW_ROW: begin
          sw_len_r  <= (eff_w > hwm_r) ? eff_w : hwm_r;
          sw_emit_r <= have_upper_r ? eff_w : '0;
        end
        bwpm_pkg::SW_MAP_UPPER: begin
          sw_len_r  <= eff_w;
          sw_emit_r <= eff_w;
        end
        default: begin
          sw_len_r  <= col_inc;
          sw_emit_r <= col_inc;
        end
      endcase
    end else if (sw_rd) begin
      pidx_r <= sw_j_r[CW-1:0];
      sw_j_r <= sw_j_r + WW'(1);
    end
  end

  // Output register: holds a beat until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r     <= emit_value;
      out_row_last_r  <= last_emit;
      out_run_last_r  <= last_emit && (sw_mode_r != bwpm_pkg::SW_MAP_UPPER);
      out_any_found_r <= last_emit && (sw_mode_r == bwpm_pkg::SW_MAP_LOWER) && found_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_value = out_value_r;
  assign out_row_last   = out_row_last_r;
  assign out_run_last   = out_run_last_r;
  assign out_any_found  = out_any_found_r;

  // Status toward the controller.
  assign sts.row_end    = row_end;
  assign sts.map_end    = map_end_r;
  assign sts.have_upper = have_upper_r;
  assign sts.sweep_busy = sw_act_r;

endmodule

// ===== hw/rtl/binary_window_pattern_marker_unit.sv =====
// Top level of the binary window pattern marker: controller plus datapath.
// A cell that does not end a row is accepted with a row memory read, then gets the window
// check and write-back of the previous column. A row end adds a flush and a sweep over
// max(width, widest row seen) columns, then closes it; result stalls stretch the sweep.
// Map end adds a flush, a sweep of the upper row (if any) and one of the last row's cells.
// Reset is synchronous: map state, flags and the output valid are cleared; row memory is not.
module binary_window_pattern_marker_unit #(
  parameter int MAX_COLS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_cell_bit,
  input  logic                            in_map_end,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_cell_value,
  output logic                            out_row_last,
  output logic                            out_run_last,
  output logic                            out_any_found,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bwpm_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [bwpm_pkg::CFG_DATA_W-1:0] cfg_data
);

  bwpm_pkg::dp_cmd_t cmd;
  bwpm_pkg::dp_sts_t sts;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  bwpm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bwpm_datapath #(
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_cell_bit    (in_cell_bit),
    .in_map_end     (in_map_end),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_value (out_cell_value),
    .out_row_last   (out_row_last),
    .out_run_last   (out_run_last),
    .out_any_found  (out_any_found)
  );

endmodule

// ===== hw/rtl/bwpm_checker.sv =====
// Port-level checker for the binary window pattern marker and its bind.
module bwpm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_cell_value,
  input logic       out_row_last,
  input logic       out_run_last,
  input logic       out_any_found
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_cell_value, out_row_last, out_run_last, out_any_found}))
    else $error("result beat changed while stalled");

  // One cell at a time: an accepted beat closes the input for the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while previous cell still in work");

  // The last beat of a run always closes a row.
  a_run_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_last |-> out_row_last)
    else $error("run ended inside a row");

  // The found flag only rides on the last beat of a run.
  a_found_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_any_found |-> out_run_last)
    else $error("found flag away from the run end");

endmodule

bind binary_window_pattern_marker_unit bwpm_checker u_bwpm_checker (.*);

// ===== dv/bwpm_checker.sv =====
// Scoreboard for the binary window pattern marker: predicts every result beat and compares.
`timescale 1ns / 100ps

module bwpm_scoreboard (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            in_cell_bit,
  input  logic                            in_map_end,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [1:0]                      out_cell_value,
  input  logic                            out_row_last,
  input  logic                            out_run_last,
  input  logic                            out_any_found,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [bwpm_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [bwpm_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending_count
);

  localparam int ROW_CELLS = 16;

  typedef struct packed {
    logic [1:0] cell_value;
    logic       row_last;
    logic       run_last;
    logic       any_found;
  } cell_beat_t;

  // Mirror of the block: configuration, the two rows in progress and map flags.
  logic [4:0]   width_reg;
  logic [3:0]   pattern_reg;
  logic [1:0]   top_cells [ROW_CELLS];
  logic [1:0]   new_cells [ROW_CELLS];
  logic [3:0]   col_idx;
  bit           have_top;
  bit           matched_any;
  cell_beat_t   cell_q[$];

  // Row width actually used, after clamping the register into range.
  function automatic int unsigned cols_in_use();
    if (width_reg < bwpm_pkg::MIN_COLS) return bwpm_pkg::MIN_COLS;
    if (width_reg > ROW_CELLS) return ROW_CELLS;
    return 32'(width_reg);
  endfunction

  // Queue one row of cell beats, taken from the upper or the lower row.
  task automatic queue_row(input bit from_top, input int unsigned len);
    cell_beat_t beat;
    for (int unsigned j = 0; j < len && j < ROW_CELLS; j++) begin
      beat.cell_value = from_top ? top_cells[j] : new_cells[j];
      beat.row_last   = (j + 1 == len);
      beat.run_last   = 1'b0;
      beat.any_found  = 1'b0;
      cell_q.push_back(beat);
    end
  endtask

  // Store one cell, check the window it completes, and queue any finished rows.
  task automatic mark_and_emit(input bit cell_in, input bit map_last);
    int unsigned w;
    int unsigned c;
    int unsigned first_new;
    cell_beat_t  tail;
    w = cols_in_use();
    c = 32'(col_idx);
    first_new = cell_q.size();
    new_cells[c] = {1'b0, cell_in};

    // A window matches on its bottom-right cell; marked cells never match again.
    if (have_top && c >= 1) begin
      if (top_cells[c-1] == {1'b0, pattern_reg[0]} &&
          top_cells[c]   == {1'b0, pattern_reg[1]} &&
          new_cells[c-1] == {1'b0, pattern_reg[2]} &&
          new_cells[c]   == {1'b0, pattern_reg[3]}) begin
        top_cells[c-1] = bwpm_pkg::CELL_MARK;
        top_cells[c]   = bwpm_pkg::CELL_MARK;
        new_cells[c-1] = bwpm_pkg::CELL_MARK;
        new_cells[c]   = bwpm_pkg::CELL_MARK;
        matched_any    = 1'b1;
      end
    end

    if (map_last) begin
      if (have_top) queue_row(1'b1, w);
      queue_row(1'b0, c + 1);
      tail = cell_q[cell_q.size()-1];
      tail.any_found = matched_any;
      cell_q[cell_q.size()-1] = tail;
      col_idx     = '0;
      have_top    = 1'b0;
      matched_any = 1'b0;
    end else if (c + 1 >= w) begin
      if (have_top) queue_row(1'b1, w);
      top_cells = new_cells;
      have_top  = 1'b1;
      col_idx   = '0;
    end else begin
      col_idx = 4'(c + 1);
    end

    if (cell_q.size() > first_new) begin
      tail = cell_q[cell_q.size()-1];
      tail.run_last = 1'b1;
      cell_q[cell_q.size()-1] = tail;
    end
  endtask

  // Sample all three channels on the rising edge.
  always @(posedge clk) begin
    cell_beat_t want;
    if (!rst_n) begin
      width_reg   = bwpm_pkg::MAP_WIDTH_RST;
      pattern_reg = bwpm_pkg::PATTERN_RST;
      for (int i = 0; i < ROW_CELLS; i++) begin
        top_cells[i] = '0;
        new_cells[i] = '0;
      end
      col_idx     = '0;
      have_top    = 1'b0;
      matched_any = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bwpm_pkg::CFG_MAP_WIDTH: width_reg = cfg_data;
          bwpm_pkg::CFG_PATTERN: pattern_reg = cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) mark_and_emit(in_cell_bit, in_map_end);

      // Compare each result beat with the oldest prediction.
      if (out_valid && out_ready) begin
        if (cell_q.size() == 0) begin
          $error("result beat with nothing expected: cell_value %0d", out_cell_value);
          fail_count++;
        end else begin
          want = cell_q.pop_front();
          if (out_cell_value !== want.cell_value) begin
            $error("cell_value mismatch: expected %0d, got %0d",
                   want.cell_value, out_cell_value);
            fail_count++;
          end
          if (out_row_last !== want.row_last) begin
            $error("row_last mismatch: expected %0d, got %0d", want.row_last, out_row_last);
            fail_count++;
          end
          if (out_run_last !== want.run_last) begin
            $error("run_last mismatch: expected %0d, got %0d", want.run_last, out_run_last);
            fail_count++;
          end
          if (out_any_found !== want.any_found) begin
            $error("any_found mismatch: expected %0d, got %0d",
                   want.any_found, out_any_found);
            fail_count++;
          end
        end
      end
    end
    pending_count = cell_q.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the binary window pattern marker: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 64;
  localparam int RANDOM_ITEMS   = 230;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            in_cell_bit = 1'b0;
  logic                            in_map_end = 1'b0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [1:0]                      out_cell_value;
  logic                            out_row_last;
  logic                            out_run_last;
  logic                            out_any_found;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [bwpm_pkg::CFG_ADDR_W-1:0] cfg_index = '0;
  logic [bwpm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int fail_total;
  int pending;
  int quiet_cycles = 0;

  // Stimulus knobs; the sender and the receiver share calm and hold_req.
  bit calm = 1'b0;
  int unsigned hold_req = 0;
  int unsigned cur_cols = 32'(bwpm_pkg::MAP_WIDTH_RST);

  always #6 clk = ~clk;

  binary_window_pattern_marker_unit uut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_cell_bit, .in_map_end,
    .out_valid, .out_ready, .out_cell_value, .out_row_last, .out_run_last, .out_any_found,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  bwpm_scoreboard u_scoreboard (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_cell_bit, .in_map_end,
    .out_valid, .out_ready, .out_cell_value, .out_row_last, .out_run_last, .out_any_found,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count(fail_total),
    .pending_count(pending)
  );

  // Idle length between beats: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Width register value, biased toward narrow rows with some out-of-range values.
  function automatic logic [4:0] pick_width();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 5'($urandom_range(2, 5));
    if (r < 65) return 5'($urandom_range(6, 15));
    if (r < 75) return 5'd16;
    if (r < 85) return 5'($urandom_range(0, 1));
    return 5'($urandom_range(17, 31));
  endfunction

  function automatic int unsigned cols_for(input logic [4:0] val);
    if (val < bwpm_pkg::MIN_COLS) return bwpm_pkg::MIN_COLS;
    if (val > 16) return 16;
    return 32'(val);
  endfunction

  // Offer one cell beat and hold it until the block takes it.
  task automatic push_cell(input bit cell_bit, input bit last);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_cell_bit <= cell_bit;
    in_map_end  <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [bwpm_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [bwpm_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering, wait for every predicted beat, then let a row sweep finish.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off whenever requested.
  initial begin
    int unsigned stall_left;
    int unsigned gap;
    int unsigned holds_seen;
    stall_left = 0;
    holds_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_req != holds_seen) begin
        holds_seen = hold_req;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        gap = idle_len();
        out_ready <= (gap == 0);
        if (gap > 0) stall_left = gap - 1;
      end
    end
  end

  // Watchdog: too long without any accepted beat ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("binary_window_pattern_marker_unit test failed");
      $finish;
    end
  end

  initial begin
    int unsigned rand_items;
    int unsigned map_no;
    int unsigned rows;
    int unsigned last_col;
    int unsigned density;
    logic [4:0]  wv;
    bit          cut;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Full 16-cell single-row map first, so every row entry holds a written value.
    write_reg(bwpm_pkg::CFG_MAP_WIDTH, 5'd16);
    cur_cols = 16;
    write_reg(bwpm_pkg::CFG_PATTERN, 5'd9);
    for (int col = 0; col < 16; col++) push_cell((col % 3) == 0, col == 15);

    // Width below range acts as 2; all-ones pattern with bit 4 of the data set.
    settle();
    write_reg(bwpm_pkg::CFG_MAP_WIDTH, 5'd0);
    cur_cols = 2;
    write_reg(bwpm_pkg::CFG_PATTERN, 5'd31);
    for (int k = 0; k < 5; k++) push_cell(1'b1, k == 4);

    // Width raised past range mid-map: the upper row goes out 16 wide with stale cells.
    push_cell(1'b0, 1'b0);
    push_cell(1'b1, 1'b0);
    settle();
    write_reg(bwpm_pkg::CFG_MAP_WIDTH, 5'd31);
    cur_cols = 16;
    push_cell(1'b1, 1'b1);

    // Random maps: mostly whole rows, some cut short, some single cells.
    rand_items = 0;
    map_no = 0;
    while (rand_items < RANDOM_ITEMS) begin
      settle();
      if ($urandom_range(0, 2) != 0) begin
        wv = pick_width();
        write_reg(bwpm_pkg::CFG_MAP_WIDTH, wv);
        cur_cols = cols_for(wv);
      end
      if ($urandom_range(0, 1) == 1) begin
        write_reg(bwpm_pkg::CFG_PATTERN, 5'($urandom_range(0, 31)));
      end
      calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 2))
        0: density = 10;
        1: density = 50;
        default: density = 90;
      endcase

      if (map_no % 8 == 1) begin
        hold_req++;
        rows = 4;
        cut = 1'b0;
      end else begin
        rows = $urandom_range(1, 4);
        cut = ($urandom_range(0, 3) == 0);
      end

      if (map_no % 8 != 1 && $urandom_range(0, 9) == 0) begin
        push_cell(1'($urandom_range(0, 1)), 1'b1);
        rand_items++;
      end else begin
        for (int unsigned r = 0; r < rows; r++) begin
          last_col = (r == rows - 1 && cut) ? $urandom_range(0, cur_cols - 1) : cur_cols - 1;
          for (int unsigned col = 0; col <= last_col; col++) begin
            push_cell($urandom_range(0, 99) < density, (r == rows - 1) && (col == last_col));
            rand_items++;
          end
          // Now and then change the width between two rows of the same map.
          if (r < rows - 1 && $urandom_range(0, 9) == 0) begin
            settle();
            wv = pick_width();
            write_reg(bwpm_pkg::CFG_MAP_WIDTH, wv);
            cur_cols = cols_for(wv);
          end
        end
      end
      map_no++;
    end

    settle();
    if (fail_total == 0 && pending == 0) begin
      $display("binary_window_pattern_marker_unit test passed");
    end else begin
      $display("binary_window_pattern_marker_unit test failed");
    end
    $finish;
  end

endmodule
